>>> src/rrpg_pkg.sv
// ----------------------------------------------------------------------------
// rrpg_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package rrpg_pkg;

   localparam int COORD_BITS_DEF   = 13;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN        = 24;

   localparam int COLOR_W  = 17;
   localparam int AMOUNT_W = 17;
   localparam int ROT_W    = 16;
   localparam int CENTER_W = 17;
   localparam int OUT_W    = 18;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 17;

   // angle in 2^-24 turn, carried with headroom
   localparam int ANG_W    = 26;
   // vectoring datapath: offsets scaled by 2^12, plus cordic growth
   localparam int VEC_W    = 36;
   // rotation datapath
   localparam int SIN_W    = 33;

   localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(8388608);
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(4194304);
   localparam logic signed [SIN_W-1:0] SINE_START   = SIN_W'(652032874);
   localparam logic signed [OUT_W-1:0] GAIN_ONE     = OUT_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CENTER_X    = 3'd0,
      REG_CENTER_Y    = 3'd1,
      REG_RAY_AMOUNT  = 3'd2,
      REG_ROTATION    = 3'd3,
      REG_COLOR_RED   = 3'd4,
      REG_COLOR_GREEN = 3'd5,
      REG_COLOR_BLUE  = 3'd6,
      REG_COLOR_ALPHA = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [AMOUNT_W-1:0] ray_amount;
      logic [ROT_W-1:0]    rotation;
      logic [COLOR_W-1:0]  color_red;
      logic [COLOR_W-1:0]  color_green;
      logic [COLOR_W-1:0]  color_blue;
      logic [COLOR_W-1:0]  color_alpha;
   } csr_type;

   function automatic logic signed [ANG_W-1:0] arc_angle(input int i);
      logic signed [ANG_W-1:0] t;
      case (i)
         0:  t = ANG_W'(2097152);
         1:  t = ANG_W'(1238021);
         2:  t = ANG_W'(654136);
         3:  t = ANG_W'(332050);
         4:  t = ANG_W'(166669);
         5:  t = ANG_W'(83416);
         6:  t = ANG_W'(41718);
         7:  t = ANG_W'(20860);
         8:  t = ANG_W'(10430);
         9:  t = ANG_W'(5215);
         10: t = ANG_W'(2608);
         11: t = ANG_W'(1304);
         12: t = ANG_W'(652);
         13: t = ANG_W'(326);
         14: t = ANG_W'(163);
         15: t = ANG_W'(81);
         16: t = ANG_W'(41);
         17: t = ANG_W'(20);
         18: t = ANG_W'(10);
         19: t = ANG_W'(5);
         20: t = ANG_W'(3);
         21: t = ANG_W'(1);
         22: t = ANG_W'(1);
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

>>> src/rrpg_req_if.sv
// ----------------------------------------------------------------------------
// rrpg_req_if / rrpg_rsp_if
// valid/ready channels for pixel coordinates and colored results
// ----------------------------------------------------------------------------
interface rrpg_req_if #(parameter int COORD_BITS = 13);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface rrpg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] red;
   logic signed [17:0] green;
   logic signed [17:0] blue;
   logic signed [17:0] alpha;
   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

>>> src/rrpg_vector_stage.sv
// ----------------------------------------------------------------------------
// rrpg_vector_stage
// one registered vectoring cordic iteration with a side payload
// ----------------------------------------------------------------------------
module rrpg_vector_stage
   import rrpg_pkg::*;
#(
   parameter int STEP   = 0,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_in,
   input  logic signed [VEC_W-1:0] x_in,
   input  logic signed [VEC_W-1:0] y_in,
   input  logic signed [ANG_W-1:0] z_in,
   input  logic [SIDE_W-1:0]       side_in,
   output logic                    valid_out,
   output logic signed [VEC_W-1:0] x_out,
   output logic signed [VEC_W-1:0] y_out,
   output logic signed [ANG_W-1:0] z_out,
   output logic [SIDE_W-1:0]       side_out
);
   logic                    valid_ff;
   logic signed [VEC_W-1:0] x_ff, y_ff, x_in_n, y_in_n;
   logic signed [ANG_W-1:0] z_ff, z_in_n;
   logic [SIDE_W-1:0]       side_ff;

   always_comb begin
      if (y_in > 0) begin
         x_in_n = x_in + (y_in >>> STEP);
         y_in_n = y_in - (x_in >>> STEP);
         z_in_n = z_in + arc_angle(STEP);
      end else begin
         x_in_n = x_in - (y_in >>> STEP);
         y_in_n = y_in + (x_in >>> STEP);
         z_in_n = z_in - arc_angle(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         x_ff    <= x_in_n;
         y_ff    <= y_in_n;
         z_ff    <= z_in_n;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign side_out  = side_ff;
endmodule

>>> src/rrpg_sine_stage.sv
// ----------------------------------------------------------------------------
// rrpg_sine_stage
// one registered rotation cordic iteration with a side payload
// ----------------------------------------------------------------------------
module rrpg_sine_stage
   import rrpg_pkg::*;
#(
   parameter int STEP   = 0,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_in,
   input  logic signed [SIN_W-1:0] x_in,
   input  logic signed [SIN_W-1:0] y_in,
   input  logic signed [ANG_W-1:0] z_in,
   input  logic [SIDE_W-1:0]       side_in,
   output logic                    valid_out,
   output logic signed [SIN_W-1:0] x_out,
   output logic signed [SIN_W-1:0] y_out,
   output logic signed [ANG_W-1:0] z_out,
   output logic [SIDE_W-1:0]       side_out
);
   logic                    valid_ff;
   logic signed [SIN_W-1:0] x_ff, y_ff, x_in_n, y_in_n;
   logic signed [ANG_W-1:0] z_ff, z_in_n;
   logic [SIDE_W-1:0]       side_ff;

   always_comb begin
      if (z_in >= 0) begin
         x_in_n = x_in - (y_in >>> STEP);
         y_in_n = y_in + (x_in >>> STEP);
         z_in_n = z_in - arc_angle(STEP);
      end else begin
         x_in_n = x_in + (y_in >>> STEP);
         y_in_n = y_in - (x_in >>> STEP);
         z_in_n = z_in + arc_angle(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         x_ff    <= x_in_n;
         y_ff    <= y_in_n;
         z_ff    <= z_in_n;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign side_out  = side_ff;
endmodule

>>> src/radial_ray_pattern_generator.sv
// ----------------------------------------------------------------------------
// radial_ray_pattern_generator
// sunburst test pattern: angle of pixel about a center, times ray count,
// sine, scaled by four channel gains
// ----------------------------------------------------------------------------
// path from req beat to rsp beat: stage 0, vectoring chain, stages a, b, c, rotation chain, stages d, e
// throughput: one beat per cycle while rsp is not stalled, set by the fully pipelined cordic chains
// every stage advances together; a stalled rsp holds the whole pipe
// reset: synchronous, clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module radial_ray_pattern_generator
   import rrpg_pkg::*;
#(
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rrpg_req_if.sink              req,
   rrpg_rsp_if.source            rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);
   localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   // offset width: scaled coordinate or center, whichever is wider, plus two bits
   localparam int DW = ((COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W) + 2;

   // whole pipe moves when the output slot is free or being taken
   logic advance;
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // ---------------- configuration registers ----------------
   csr_type csr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.center_x    <= CENTER_W'(15360);
         csr_ff.center_y    <= CENTER_W'(8640);
         csr_ff.ray_amount  <= AMOUNT_W'(2560);
         csr_ff.rotation    <= '0;
         csr_ff.color_red   <= COLOR_W'(65536);
         csr_ff.color_green <= COLOR_W'(65536);
         csr_ff.color_blue  <= COLOR_W'(65536);
         csr_ff.color_alpha <= COLOR_W'(65536);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_CENTER_X:    csr_ff.center_x    <= csr_write_data;
            REG_CENTER_Y:    csr_ff.center_y    <= csr_write_data;
            REG_RAY_AMOUNT:  csr_ff.ray_amount  <= csr_write_data;
            REG_ROTATION:    csr_ff.rotation    <= csr_write_data[ROT_W-1:0];
            REG_COLOR_RED:   csr_ff.color_red   <= csr_write_data;
            REG_COLOR_GREEN: csr_ff.color_green <= csr_write_data;
            REG_COLOR_BLUE:  csr_ff.color_blue  <= csr_write_data;
            REG_COLOR_ALPHA: csr_ff.color_alpha <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------- stage 0: offsets, scaled, pre-rotation ----------------
   logic                    s0_valid_ff;
   logic signed [VEC_W-1:0] s0_x_ff, s0_y_ff;
   logic signed [ANG_W-1:0] s0_z_ff;
   logic                    s0_zero_ff;
   logic signed [DW-1:0]    dx_in, dy_in;

   always_comb begin
      dx_in = $signed(DW'(req.pixel_x) << 4) - $signed(DW'(csr_ff.center_x));
      dy_in = $signed(DW'(req.pixel_y) << 4) - $signed(DW'(csr_ff.center_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req.valid;
      end
      if (advance) begin
         s0_zero_ff <= (dx_in == '0) && (dy_in == '0);
         // vector is (dy, dx); left half plane flipped by half a turn
         if (dy_in < 0) begin
            s0_x_ff <= VEC_W'(-dy_in) <<< 12;
            s0_y_ff <= VEC_W'(-dx_in) <<< 12;
            s0_z_ff <= HALF_TURN;
         end else begin
            s0_x_ff <= VEC_W'(dy_in) <<< 12;
            s0_y_ff <= VEC_W'(dx_in) <<< 12;
            s0_z_ff <= '0;
         end
      end
   end

   // ---------------- vectoring cordic chain ----------------
   logic                    v_valid [NS+1];
   logic signed [VEC_W-1:0] v_x [NS+1];
   logic signed [VEC_W-1:0] v_y [NS+1];
   logic signed [ANG_W-1:0] v_z [NS+1];
   logic                    v_zero [NS+1];

   assign v_valid[0] = s0_valid_ff;
   assign v_x[0]     = s0_x_ff;
   assign v_y[0]     = s0_y_ff;
   assign v_z[0]     = s0_z_ff;
   assign v_zero[0]  = s0_zero_ff;

   for (genvar i = 0; i < NS; i++) begin : g_vec
      rrpg_vector_stage #(.STEP(i), .SIDE_W(1)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (v_valid[i]),
         .x_in      (v_x[i]),
         .y_in      (v_y[i]),
         .z_in      (v_z[i]),
         .side_in   (v_zero[i]),
         .valid_out (v_valid[i+1]),
         .x_out     (v_x[i+1]),
         .y_out     (v_y[i+1]),
         .z_out     (v_z[i+1]),
         .side_out  (v_zero[i+1])
      );
   end

   // ---------------- stage a: subtract rotation, wrap, zero at center ----------------
   logic                    sa_valid_ff;
   logic signed [ANG_W-1:0] sa_ang_ff;
   logic [23:0]             wrap_in;
   logic signed [ANG_W-1:0] ang_in;

   always_comb begin
      wrap_in = 24'(v_z[NS] - $signed({2'b0, csr_ff.rotation, 8'b0}));
      ang_in  = $signed({2'b0, wrap_in});
      if (ang_in > HALF_TURN) ang_in = ang_in - (HALF_TURN <<< 1);
      if (v_zero[NS]) ang_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (advance) begin
         sa_valid_ff <= v_valid[NS];
      end
      if (advance) sa_ang_ff <= ang_in;
   end

   // ---------------- stage b: multiply by ray amount ----------------
   logic               sb_valid_ff;
   logic signed [43:0] sb_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else if (advance) begin
         sb_valid_ff <= sa_valid_ff;
      end
      if (advance) sb_prod_ff <= 44'(sa_ang_ff) * $signed({1'b0, csr_ff.ray_amount});
   end

   // ---------------- stage c: phase fold ----------------
   logic                    sc_valid_ff;
   logic signed [ANG_W-1:0] sc_ph_ff;
   logic signed [ANG_W-1:0] ph_in;

   always_comb begin
      ph_in = $signed({2'b0, sb_prod_ff[31:8]});
      if (ph_in >= HALF_TURN) ph_in = ph_in - (HALF_TURN <<< 1);
      if (ph_in > QUARTER_TURN) ph_in = HALF_TURN - ph_in;
      else if (ph_in < -QUARTER_TURN) ph_in = -HALF_TURN - ph_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else if (advance) begin
         sc_valid_ff <= sb_valid_ff;
      end
      if (advance) sc_ph_ff <= ph_in;
   end

   // ---------------- rotation cordic chain for the sine ----------------
   logic                    r_valid [NS+1];
   logic signed [SIN_W-1:0] r_x [NS+1];
   logic signed [SIN_W-1:0] r_y [NS+1];
   logic signed [ANG_W-1:0] r_z [NS+1];
   logic                    r_side [NS+1];

   assign r_valid[0] = sc_valid_ff;
   assign r_x[0]     = SINE_START;
   assign r_y[0]     = '0;
   assign r_z[0]     = sc_ph_ff;
   assign r_side[0]  = 1'b0;

   for (genvar i = 0; i < NS; i++) begin : g_sin
      rrpg_sine_stage #(.STEP(i), .SIDE_W(1)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (r_valid[i]),
         .x_in      (r_x[i]),
         .y_in      (r_y[i]),
         .z_in      (r_z[i]),
         .side_in   (r_side[i]),
         .valid_out (r_valid[i+1]),
         .x_out     (r_x[i+1]),
         .y_out     (r_y[i+1]),
         .z_out     (r_z[i+1]),
         .side_out  (r_side[i+1])
      );
   end

   // ---------------- stage d: round, clamp to q16 ----------------
   logic                    sd_valid_ff;
   logic signed [OUT_W-1:0] sd_sin_ff;
   logic signed [SIN_W-1:0] rnd_in;

   always_comb rnd_in = (r_y[NS] + SIN_W'(8192)) >>> 14;

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_valid_ff <= 1'b0;
      end else if (advance) begin
         sd_valid_ff <= r_valid[NS];
      end
      if (advance) begin
         if (rnd_in > SIN_W'(GAIN_ONE)) sd_sin_ff <= GAIN_ONE;
         else if (rnd_in < -SIN_W'(GAIN_ONE)) sd_sin_ff <= -GAIN_ONE;
         else sd_sin_ff <= OUT_W'(rnd_in);
      end
   end

   // ---------------- stage e: channel gains, output register ----------------
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] red_ff, green_ff, blue_ff, alpha_ff;

   function automatic logic signed [OUT_W-1:0] scale(input logic signed [OUT_W-1:0] s,
                                                     input logic [COLOR_W-1:0] g);
      logic signed [OUT_W-1:0] gc;
      logic signed [36:0]      p;
      gc = (g > COLOR_W'(65536)) ? GAIN_ONE : $signed({1'b0, g});
      p  = 37'(s) * 37'(gc) + 37'(32768);
      return OUT_W'(p >>> 16);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sd_valid_ff;
      end
      if (advance) begin
         red_ff   <= scale(sd_sin_ff, csr_ff.color_red);
         green_ff <= scale(sd_sin_ff, csr_ff.color_green);
         blue_ff  <= scale(sd_sin_ff, csr_ff.color_blue);
         alpha_ff <= scale(sd_sin_ff, csr_ff.color_alpha);
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.red   = red_ff;
   assign rsp.green = green_ff;
   assign rsp.blue  = blue_ff;
   assign rsp.alpha = alpha_ff;

   // ---------------- assertions ----------------
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.red))
      else $error("rsp beat changed while stalled");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("req stalled with empty output");
   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      sd_valid_ff |-> (sd_sin_ff <= GAIN_ONE) && (sd_sin_ff >= -GAIN_ONE))
      else $error("sine out of range");
   a_phase_fold: assert property (@(posedge clock) disable iff (reset)
      sc_valid_ff |-> (sc_ph_ff <= QUARTER_TURN) && (sc_ph_ff >= -QUARTER_TURN))
      else $error("phase not folded");
endmodule
